// ===== hw/rtl/mcbs_pkg.sv =====
// Shared codes, types and character helpers for the Markov chain base sampler.
package mcbs_pkg;

   localparam int BASE_COUNT = 4;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   localparam logic [1:0] SRC_COPY    = 2'd0;
   localparam logic [1:0] SRC_UNIFORM = 2'd1;
   localparam logic [1:0] SRC_MODEL   = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKOV_ORDER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_IN_USE  = 2'd1;

   localparam int ORDER_W = 3;
   localparam int BINS_W  = 4;
   localparam int K_W     = 4;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd5;
   localparam logic [BINS_W-1:0]  BINS_RESET  = 4'd1;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
   } letter_code_type;

   function automatic logic [7:0] base_letter(input logic [1:0] b);
      logic [7:0] c;
      case (b)
         2'd0:    c = 8'h41;
         2'd1:    c = 8'h43;
         2'd2:    c = 8'h47;
         default: c = 8'h54;
      endcase
      return c;
   endfunction

   function automatic letter_code_type letter_code(input logic [7:0] c);
      letter_code_type r;
      case (c)
         8'h41, 8'h61: r = '{valid: 1'b1, code: 2'd0};
         8'h43, 8'h63: r = '{valid: 1'b1, code: 2'd1};
         8'h47, 8'h67: r = '{valid: 1'b1, code: 2'd2};
         8'h54, 8'h74: r = '{valid: 1'b1, code: 2'd3};
         default:      r = '{valid: 1'b0, code: 2'd0};
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/markov_chain_base_sampler_core.sv =====
// Order-k Markov chain DNA base sampler core with its CDF table memory.
// Sample request: acceptance registers busy, and busy registers the result strobe;
// busy is high for one cycle and blocks new requests, as the registered read of
// the CDF memory uses an address from the base emitted by the previous sample.
// Load and start requests produce no result. Synchronous reset clears history,
// run length, busy and strobe, and resets order and bins; the CDF table is not
// cleared and holds undefined data until loaded. Results cannot be stalled.
module markov_chain_base_sampler_core
   import mcbs_pkg::*;
#(
   parameter int MAX_ORDER         = 5,
   parameter int MAX_BINS          = 8,
   parameter int CDF_FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_action,
   input  logic [2:0]                   req_table_bin,
   input  logic [9:0]                   req_table_context,
   input  logic [1:0]                   req_table_base,
   input  logic [CDF_FRACTION_BITS:0]   req_cdf_value,
   input  logic [CDF_FRACTION_BITS-1:0] req_random_value,
   input  logic [2:0]                   req_bin_index,
   input  logic                         req_bin_found,
   input  logic                         req_copy_from_original,
   input  logic                         req_original_available,
   input  logic [7:0]                   req_original_char,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_base_char,
   output logic [1:0]                   rsp_base_source,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CTX_BITS = 2 * MAX_ORDER;
   localparam int CDF_W    = CDF_FRACTION_BITS + 1;
   localparam int BIN_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int DEPTH    = MAX_BINS * (1 << CTX_BITS);
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int RUN_W    = $clog2(MAX_ORDER + 1);
   localparam logic [K_W-1:0]   MAX_ORDER_V = K_W'(MAX_ORDER);
   localparam logic [RUN_W-1:0] RUN_MAX     = RUN_W'(MAX_ORDER);
   localparam logic [6:0]       MAX_BINS_V  = 7'(MAX_BINS);

   // CDF table: one row per bin and context, one lane per next base
   logic [BASE_COUNT-1:0][CDF_W-1:0] cdf_mem [DEPTH];
   logic [BASE_COUNT-1:0][CDF_W-1:0] rd_ff;

   logic [ORDER_W-1:0]           order_ff;
   logic [BINS_W-1:0]            bins_ff;
   logic [CTX_BITS-1:0]          history_ff, history_in;
   logic [RUN_W-1:0]             run_ff, run_in;
   logic                         busy_ff;
   logic [CDF_FRACTION_BITS-1:0] s1_random_ff;
   logic [7:0]                   s1_char_ff;
   logic [1:0]                   s1_source_ff;
   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_char_ff;
   logic [1:0]                   rsp_source_ff;

   logic                         req_fire;
   logic                         load_fire, start_fire, sample_fire;
   logic                         mem_we;
   logic [K_W-1:0]               k_eff;
   logic [CTX_BITS-1:0]          ctx_mask;
   logic [CTX_BITS-1:0]          rd_ctx;
   logic [CTX_BITS+9:0]          tctx_ext;
   logic [BIN_W+2:0]             tbin_ext, sbin_ext;
   logic [BIN_W+CTX_BITS-1:0]    wr_full, rd_full;
   logic [ADDR_W-1:0]            wr_addr, rd_addr;
   logic                         run_ok, bin_ok, use_model, do_copy;
   logic [1:0]                   uni_base;
   logic [7:0]                   s1_char_in;
   logic [1:0]                   s1_source_in;
   logic [1:0]                   model_base;
   logic [7:0]                   out_char;
   letter_code_type              out_code;
   logic [CTX_BITS+1:0]          hist_shift;

   assign req_fire    = start && !busy_ff;
   assign load_fire   = req_fire && (req_action == ACT_LOAD);
   assign start_fire  = req_fire && (req_action == ACT_START);
   assign sample_fire = req_fire && (req_action == ACT_SAMPLE);
   assign busy        = busy_ff;
   assign csr_ready   = 1'b1;

   // effective context length: clamp to 1..MAX_ORDER
   always_comb begin
      if (order_ff == '0) begin
         k_eff = K_W'(1);
      end else if (K_W'(order_ff) > MAX_ORDER_V) begin
         k_eff = MAX_ORDER_V;
      end else begin
         k_eff = K_W'(order_ff);
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
         ctx_mask[2*i +: 2] = (K_W'(i) < k_eff) ? 2'b11 : 2'b00;
      end
   end

   // table write address
   assign tctx_ext = {{CTX_BITS{1'b0}}, req_table_context};
   assign tbin_ext = {{BIN_W{1'b0}}, req_table_bin};
   assign wr_full  = {tbin_ext[BIN_W-1:0], tctx_ext[CTX_BITS-1:0]};
   assign wr_addr  = wr_full[ADDR_W-1:0];
   assign mem_we   = load_fire && ({4'b0000, req_table_bin} < MAX_BINS_V);

   // sample decision at acceptance
   assign rd_ctx    = history_ff & ctx_mask;
   assign sbin_ext  = {{BIN_W{1'b0}}, req_bin_index};
   assign rd_full   = {sbin_ext[BIN_W-1:0], rd_ctx};
   assign rd_addr   = rd_full[ADDR_W-1:0];
   assign run_ok    = K_W'(run_ff) >= k_eff;
   assign bin_ok    = req_bin_found && ({1'b0, req_bin_index} < bins_ff) &&
                      ({4'b0000, req_bin_index} < MAX_BINS_V);
   assign do_copy   = req_copy_from_original && req_original_available;
   assign use_model = !req_copy_from_original && run_ok && bin_ok;
   assign uni_base  = req_random_value[CDF_FRACTION_BITS-1 -: 2];

   always_comb begin
      if (do_copy) begin
         s1_char_in   = req_original_char;
         s1_source_in = SRC_COPY;
      end else if (use_model) begin
         s1_char_in   = base_letter(uni_base);
         s1_source_in = SRC_MODEL;
      end else begin
         s1_char_in   = base_letter(uni_base);
         s1_source_in = SRC_UNIFORM;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         for (int b = 0; b < BASE_COUNT; b++) begin
            if (req_table_base == 2'(b)) begin
               cdf_mem[wr_addr][b] <= req_cdf_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sample_fire) begin
         rd_ff <= cdf_mem[rd_addr];
      end
   end

   // first base whose CDF exceeds the random value, else T
   always_comb begin
      model_base = 2'd3;
      for (int b = BASE_COUNT - 1; b >= 0; b--) begin
         if ({1'b0, s1_random_ff} < rd_ff[b]) begin
            model_base = 2'(b);
         end
      end
      out_char = (s1_source_ff == SRC_MODEL) ? base_letter(model_base) : s1_char_ff;
      out_code = letter_code(out_char);
   end

   // history advance on completed sample, clear on start
   always_comb begin
      hist_shift = {history_ff, (out_code.valid ? out_code.code : 2'b00)};
      history_in = history_ff;
      run_in     = run_ff;
      if (start_fire) begin
         history_in = '0;
         run_in     = '0;
      end else if (busy_ff) begin
         history_in = hist_shift[CTX_BITS-1:0];
         if (!out_code.valid) begin
            run_in = '0;
         end else if (run_ff != RUN_MAX) begin
            run_in = run_ff + RUN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= ORDER_RESET;
         bins_ff      <= BINS_RESET;
         history_ff   <= '0;
         run_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MARKOV_ORDER: order_ff <= csr_wdata[ORDER_W-1:0];
               CSR_BINS_IN_USE:  bins_ff  <= csr_wdata[BINS_W-1:0];
               default:          ;
            endcase
         end
         history_ff   <= history_in;
         run_ff       <= run_in;
         busy_ff      <= sample_fire;
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_fire) begin
         s1_random_ff <= req_random_value;
         s1_char_ff   <= s1_char_in;
         s1_source_ff <= s1_source_in;
      end
      if (busy_ff) begin
         rsp_char_ff   <= out_char;
         rsp_source_ff <= s1_source_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_base_char   = rsp_char_ff;
   assign rsp_base_source = rsp_source_ff;

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held longer than one cycle");

   a_result_follows_sample: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid)
      else $error("sample request produced no result");

   a_result_has_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy_ff))
      else $error("result without a sample request");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_MAX)
      else $error("valid run length beyond order limit");

endmodule

// ===== verif/markov_chain_base_sampler_core_tb.sv =====
// Self-checking testbench for the Markov chain base sampler core.
module markov_chain_base_sampler_core_tb;
   import mcbs_pkg::*;

   localparam int MAX_ORDER         = 5;
   localparam int MAX_BINS          = 8;
   localparam int CDF_FRACTION_BITS = 16;
   localparam int CDF_W             = CDF_FRACTION_BITS + 1;
   localparam int CTX_COUNT         = 1 << (2 * MAX_ORDER);
   localparam int CDF_DEPTH         = MAX_BINS * CTX_COUNT * BASE_COUNT;
   localparam int CDF_ONE           = 1 << CDF_FRACTION_BITS;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_B = 2'd3;

   localparam int ITEM_COUNT     = 1450;
   localparam int PHASE_COUNT    = 8;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic [1:0]                   action;
      logic [2:0]                   tbin;
      logic [9:0]                   tctx;
      logic [1:0]                   tbase;
      logic [CDF_FRACTION_BITS:0]   cdf;
      logic [CDF_FRACTION_BITS-1:0] rnd;
      logic [2:0]                   bin;
      logic                         found;
      logic                         copy;
      logic                         avail;
      logic [7:0]                   ochar;
   } request_type;

   typedef struct {
      logic [7:0] ch;
      logic [1:0] src;
   } base_result_type;

   class sampler_shadow;
      logic [CDF_FRACTION_BITS:0] cdf_table [CDF_DEPTH];
      bit                         loaded    [CDF_DEPTH];
      logic [2*MAX_ORDER-1:0]     history;
      int unsigned                run_len;
      logic [2:0]                 order_reg;
      logic [3:0]                 bins_reg;
      base_result_type            expected_bases [$];
      int unsigned                errors;

      function new();
         history   = '0;
         run_len   = 0;
         order_reg = ORDER_RESET;
         bins_reg  = BINS_RESET;
         errors    = 0;
      endfunction

      function logic [7:0] base_ascii(int b);
         case (b)
            0:       return "A";
            1:       return "C";
            2:       return "G";
            default: return "T";
         endcase
      endfunction

      function int base_code(logic [7:0] c);
         case (c)
            "A", "a": return 0;
            "C", "c": return 1;
            "G", "g": return 2;
            "T", "t": return 3;
            default:  return -1;
         endcase
      endfunction

      function int unsigned order_k();
         if (order_reg < 1) return 1;
         if (order_reg > MAX_ORDER) return MAX_ORDER;
         return order_reg;
      endfunction

      function bit uses_model(request_type r);
         return !r.copy && run_len >= order_k() && r.found &&
                {1'b0, r.bin} < bins_reg && r.bin < MAX_BINS;
      endfunction

      function int unsigned row_base(request_type r);
         int unsigned ctx;
         ctx = history & ((1 << (2 * order_k())) - 1);
         return (r.bin * CTX_COUNT + ctx) * BASE_COUNT;
      endfunction

      // A model draw must only see entries that were loaded.
      function bit row_missing(request_type r);
         int unsigned rb;
         if (!uses_model(r)) return 0;
         rb = row_base(r);
         for (int b = 0; b < BASE_COUNT; b++)
            if (!loaded[rb + b]) return 1;
         return 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_MARKOV_ORDER) order_reg = data[2:0];
         else if (idx == CSR_BINS_IN_USE) bins_reg = data[3:0];
      endfunction

      function void note_request(request_type r);
         int unsigned     addr;
         int              pick;
         int              code;
         bit              hit;
         base_result_type e;
         case (r.action)
            ACT_LOAD: begin
               addr = (r.tbin * CTX_COUNT + r.tctx) * BASE_COUNT + r.tbase;
               cdf_table[addr] = r.cdf;
               loaded[addr]    = 1'b1;
            end
            ACT_START: begin
               history = '0;
               run_len = 0;
            end
            ACT_SAMPLE: begin
               pick  = r.rnd[CDF_FRACTION_BITS-1 -: 2];
               e.src = SRC_UNIFORM;
               e.ch  = base_ascii(pick);
               if (r.copy) begin
                  if (r.avail) begin
                     e.ch  = r.ochar;
                     e.src = SRC_COPY;
                  end
               end else if (uses_model(r)) begin
                  addr = row_base(r);
                  pick = BASE_COUNT - 1;
                  hit  = 0;
                  for (int b = 0; b < BASE_COUNT; b++)
                     if (!hit && {1'b0, r.rnd} < cdf_table[addr + b]) begin
                        pick = b;
                        hit  = 1;
                     end
                  e.ch  = base_ascii(pick);
                  e.src = SRC_MODEL;
               end
               // Shift the emitted base into the context; a non-base breaks the run.
               code = base_code(e.ch);
               if (code < 0) begin
                  history = {history[2*MAX_ORDER-3:0], 2'b00};
                  run_len = 0;
               end else begin
                  history = {history[2*MAX_ORDER-3:0], 2'(code)};
                  if (run_len < MAX_ORDER) run_len++;
               end
               expected_bases.insert(expected_bases.size(), e);
            end
            default: ;
         endcase
      endfunction

      function void check_base(logic [7:0] ch, logic [1:0] src);
         base_result_type e;
         if (expected_bases.size() == 0) begin
            errors++;
            $error("unexpected result: base_char %h base_source %0d", ch, src);
            return;
         end
         e = expected_bases.pop_front();
         if (ch !== e.ch) begin
            errors++;
            $error("base_char mismatch: expected %h actual %h", e.ch, ch);
         end
         if (src !== e.src) begin
            errors++;
            $error("base_source mismatch: expected %0d actual %0d", e.src, src);
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_action = '0;
   logic [2:0]                   req_table_bin = '0;
   logic [9:0]                   req_table_context = '0;
   logic [1:0]                   req_table_base = '0;
   logic [CDF_FRACTION_BITS:0]   req_cdf_value = '0;
   logic [CDF_FRACTION_BITS-1:0] req_random_value = '0;
   logic [2:0]                   req_bin_index = '0;
   logic                         req_bin_found = 1'b0;
   logic                         req_copy_from_original = 1'b0;
   logic                         req_original_available = 1'b0;
   logic [7:0]                   req_original_char = '0;
   logic                         rsp_valid;
   logic [7:0]                   rsp_base_char;
   logic [1:0]                   rsp_base_source;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   sampler_shadow shadow = new();
   int            items_sent = 0;
   int            burst_left = 0;
   int            stall_cycles = 0;
   int            phase_order [PHASE_COUNT] = '{1, 0, 7, 3, 6, 2, 4, 5};
   int            phase_bins  [PHASE_COUNT] = '{8, 15, 0, 4, 8, 2, 1, 8};

   markov_chain_base_sampler_core #(
      .MAX_ORDER         (MAX_ORDER),
      .MAX_BINS          (MAX_BINS),
      .CDF_FRACTION_BITS (CDF_FRACTION_BITS)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_table_bin          (req_table_bin),
      .req_table_context      (req_table_context),
      .req_table_base         (req_table_base),
      .req_cdf_value          (req_cdf_value),
      .req_random_value       (req_random_value),
      .req_bin_index          (req_bin_index),
      .req_bin_found          (req_bin_found),
      .req_copy_from_original (req_copy_from_original),
      .req_original_available (req_original_available),
      .req_original_char      (req_original_char),
      .rsp_valid              (rsp_valid),
      .rsp_base_char          (rsp_base_char),
      .rsp_base_source        (rsp_base_source),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function request_type blank_request(logic [1:0] act);
      request_type r;
      r.action = act;
      r.tbin   = '0;
      r.tctx   = '0;
      r.tbase  = '0;
      r.cdf    = '0;
      r.rnd    = '0;
      r.bin    = '0;
      r.found  = 1'b0;
      r.copy   = 1'b0;
      r.avail  = 1'b0;
      r.ochar  = '0;
      return r;
   endfunction

   function request_type sample_item(logic [15:0] rnd, logic [2:0] bin, logic found,
                                     logic copy, logic avail, logic [7:0] ochar);
      request_type r;
      r       = blank_request(ACT_SAMPLE);
      r.rnd   = rnd;
      r.bin   = bin;
      r.found = found;
      r.copy  = copy;
      r.avail = avail;
      r.ochar = ochar;
      return r;
   endfunction

   function request_type random_request();
      request_type r;
      int          p;
      int          nb;
      logic [7:0]  lc;
      r.action = ACT_SAMPLE;
      r.tbin   = 3'($urandom_range(0, 7));
      r.tctx   = 10'($urandom_range(0, 1023));
      r.tbase  = 2'($urandom_range(0, 3));
      r.cdf    = CDF_W'($urandom_range(0, CDF_ONE));
      r.rnd    = CDF_FRACTION_BITS'($urandom_range(0, CDF_ONE - 1));
      r.bin    = 3'($urandom_range(0, 7));
      r.found  = 1'($urandom_range(0, 1));
      r.copy   = 1'($urandom_range(0, 1));
      r.avail  = 1'($urandom_range(0, 1));
      r.ochar  = 8'($urandom_range(0, 255));
      p = $urandom_range(0, 99);
      if (p < 12) r.action = ACT_LOAD;
      else if (p < 15) r.action = ACT_START;
      else if (p < 18) r.action = ACT_UNUSED;
      else begin
         r.copy  = ($urandom_range(0, 99) < 12);
         r.avail = ($urandom_range(0, 9) < 7);
         if ($urandom_range(0, 9) < 6) begin
            lc      = ($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00;
            r.ochar = shadow.base_ascii($urandom_range(0, 3)) | lc;
         end
         r.found = ($urandom_range(0, 9) != 0);
         nb = (shadow.bins_reg > MAX_BINS) ? MAX_BINS : shadow.bins_reg;
         if (nb > 0 && $urandom_range(0, 9) < 7) r.bin = 3'($urandom_range(0, nb - 1));
      end
      return r;
   endfunction

   // Bursts of back-to-back requests separated by random gaps.
   function int next_gap();
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
      end
      burst_left--;
      return gap;
   endfunction

   task send_request(request_type r);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                  <= 1'b1;
      req_action             <= r.action;
      req_table_bin          <= r.tbin;
      req_table_context      <= r.tctx;
      req_table_base         <= r.tbase;
      req_cdf_value          <= r.cdf;
      req_random_value       <= r.rnd;
      req_bin_index          <= r.bin;
      req_bin_found          <= r.found;
      req_copy_from_original <= r.copy;
      req_original_available <= r.avail;
      req_original_char      <= r.ochar;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_request(r);
      if (r.action != ACT_UNUSED) items_sent++;
   endtask

   task load_row(int unsigned rb);
      int          v [BASE_COUNT];
      int          t;
      request_type r;
      for (int b = 0; b < BASE_COUNT; b++) v[b] = $urandom_range(0, CDF_ONE);
      // Mostly a proper CDF; now and then leave it unsorted.
      if ($urandom_range(0, 7) != 0)
         for (int i = 0; i < BASE_COUNT - 1; i++)
            for (int j = 0; j < BASE_COUNT - 1 - i; j++)
               if (v[j] > v[j+1]) begin
                  t      = v[j];
                  v[j]   = v[j+1];
                  v[j+1] = t;
               end
      if ($urandom_range(0, 1)) v[BASE_COUNT-1] = CDF_ONE;
      for (int b = 0; b < BASE_COUNT; b++) begin
         r        = random_request();
         r.action = ACT_LOAD;
         r.tbin   = rb[14:12];
         r.tctx   = rb[11:2];
         r.tbase  = 2'(b);
         r.cdf    = CDF_W'(v[b]);
         send_request(r);
      end
   endtask

   // Load the row a model draw would read, then send the request.
   task issue(request_type r, bit near_edges);
      int unsigned rb;
      int unsigned v;
      if (r.action == ACT_SAMPLE && shadow.row_missing(r)) load_row(shadow.row_base(r));
      if (near_edges && r.action == ACT_SAMPLE && shadow.uses_model(r) &&
          $urandom_range(0, 3) == 0) begin
         rb = shadow.row_base(r);
         v  = shadow.cdf_table[rb + $urandom_range(0, BASE_COUNT - 1)];
         if (v > CDF_ONE - 1) r.rnd = CDF_FRACTION_BITS'(CDF_ONE - 1);
         else if (v != 0 && $urandom_range(0, 1)) r.rnd = CDF_FRACTION_BITS'(v - 1);
         else r.rnd = CDF_FRACTION_BITS'(v);
      end
      send_request(r);
   endtask

   task csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.write_register(idx, data);
   endtask

   task wait_idle();
      start <= 1'b0;
      while (shadow.expected_bases.size() != 0) @(posedge clock);
      // Loads and starts leave no result to wait for.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      request_type r;
      int          target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      r        = blank_request(ACT_UNUSED);
      r.tbin   = 3'd7;
      r.tctx   = 10'h3FF;
      r.tbase  = 2'd3;
      r.cdf    = CDF_W'(CDF_ONE);
      r.rnd    = 16'hFFFF;
      r.bin    = 3'd7;
      r.found  = 1'b1;
      r.copy   = 1'b1;
      r.avail  = 1'b1;
      r.ochar  = 8'hFF;
      issue(r, 0);
      r        = blank_request(ACT_LOAD);
      r.tbin   = 3'd7;
      r.tctx   = 10'h3FF;
      r.tbase  = 2'd3;
      r.cdf    = CDF_W'(CDF_ONE);
      issue(r, 0);
      issue(blank_request(ACT_LOAD), 0);
      issue(blank_request(ACT_START), 0);
      issue(sample_item(16'h0000, 3'd0, 1'b0, 1'b1, 1'b1, "g"), 0);
      issue(sample_item(16'h0000, 3'd0, 1'b0, 1'b1, 1'b1, 8'h00), 0);
      issue(sample_item(16'h0000, 3'd0, 1'b0, 1'b1, 1'b1, 8'hFF), 0);
      issue(sample_item(16'hFFFF, 3'd0, 1'b0, 1'b1, 1'b0, 8'h00), 0);
      issue(sample_item(16'h0000, 3'd0, 1'b0, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'h4000, 3'd7, 1'b1, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'h8000, 3'd0, 1'b0, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'hC000, 3'd7, 1'b1, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'hFFFF, 3'd0, 1'b0, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'h0000, 3'd0, 1'b1, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'hFFFF, 3'd0, 1'b1, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'h8000, 3'd0, 1'b1, 1'b0, 1'b0, 8'h00), 0);
      issue(sample_item(16'h1234, 3'd0, 1'b1, 1'b0, 1'b0, 8'h00), 0);
      issue(blank_request(ACT_START), 0);
      issue(sample_item(16'h0000, 3'd0, 1'b1, 1'b1, 1'b1, "T"), 0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         if (p == 0) begin
            csr_write(CSR_UNMAPPED_A, CSR_DATA_W'($urandom_range(0, 15)));
            csr_write(CSR_UNMAPPED_B, CSR_DATA_W'($urandom_range(0, 15)));
         end
         csr_write(CSR_MARKOV_ORDER, CSR_DATA_W'(phase_order[p]));
         csr_write(CSR_BINS_IN_USE, CSR_DATA_W'(phase_bins[p]));
         csr_valid <= 1'b0;
         target = (p + 1) * ITEM_COUNT / PHASE_COUNT;
         while (items_sent < target) issue(random_request(), 1);
      end

      start <= 1'b0;
      while (shadow.expected_bases.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.errors == 0)
         $display("[markov_chain_base_sampler_core] OK");
      else
         $display("[markov_chain_base_sampler_core] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) shadow.check_base(rsp_base_char, rsp_base_source);
   end

   // Drop the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[markov_chain_base_sampler_core] ERROR");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

endmodule
